// ===== sv/i420cr_pkg.sv =====
// shared types and constants for the i420 chroma relayout mapper
package i420cr_pkg;

  localparam int unsigned OFFSET_W = 25;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned LAYOUT_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W   = 2 * DIM_W;

  localparam logic [DIM_W-1:0] MAX_WIDTH    = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [DIM_W-1:0] ROW_ALIGN_M1 = 13'd15;
  localparam logic [DIM_W-1:0] RST_WIDTH    = 13'd1920;
  localparam logic [DIM_W-1:0] RST_HEIGHT   = 13'd1080;
  localparam logic [OFFSET_W-1:0] RST_LUMA  = 25'd2073600;

  localparam logic [LAYOUT_W-1:0] LAYOUT_I420 = 2'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_YV12 = 2'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_NV12 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LAYOUT = 2'd2;

  typedef struct packed {
    logic [OFFSET_W-1:0] src_offset;
    logic [BYTE_W-1:0]   src_byte;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] dest_offset;
    logic [BYTE_W-1:0]   dest_byte;
    logic                in_frame;
  } out_item_t;

endpackage

// ===== sv/i420_chroma_relayout_mapper.sv =====
// i420 chroma relayout mapper: maps source byte offsets into i420, yv12 or nv12 layout
// pipeline: three register stages (capture, region compares, destination offset) from input transaction to result
// throughput: one transaction per cycle, each stage holds while the stage after it stalls
// reset: synchronous active-low rst_n clears all valid bits and loads 1920 x 1080, i420
// a configuration write takes effect for a transaction accepted on the following cycle
module i420_chroma_relayout_mapper (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [i420cr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [i420cr_pkg::DIM_W-1:0]           cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  i420cr_pkg::in_item_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output i420cr_pkg::out_item_t                  out_data
);

  localparam int unsigned OW = i420cr_pkg::OFFSET_W;

  logic [i420cr_pkg::DIM_W-1:0]    width_r, height_r;
  logic [i420cr_pkg::LAYOUT_W-1:0] layout_r;
  logic [OW-1:0]                   luma_r, luma_nxt;
  logic [i420cr_pkg::DIM_W-1:0]    w_sat, w_al, h_sat;
  logic [i420cr_pkg::PROD_W-1:0]   prod;
  logic [OW-1:0]                   csize, uv_bound, frame_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= i420cr_pkg::RST_WIDTH;
      height_r <= i420cr_pkg::RST_HEIGHT;
      layout_r <= i420cr_pkg::LAYOUT_I420;
    end else if (cfg_we) begin
      case (cfg_index)
        i420cr_pkg::REG_FRAME_WIDTH:   width_r  <= cfg_wdata;
        i420cr_pkg::REG_FRAME_HEIGHT:  height_r <= cfg_wdata;
        i420cr_pkg::REG_OUTPUT_LAYOUT: layout_r <= cfg_wdata[i420cr_pkg::LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // luma plane size, saturated and row aligned
  always_comb begin
    w_sat = (width_r > i420cr_pkg::MAX_WIDTH) ? i420cr_pkg::MAX_WIDTH : width_r;
    h_sat = (height_r > i420cr_pkg::MAX_HEIGHT) ? i420cr_pkg::MAX_HEIGHT : height_r;
    w_al  = (w_sat + i420cr_pkg::ROW_ALIGN_M1) & ~i420cr_pkg::ROW_ALIGN_M1;
    prod  = {{i420cr_pkg::DIM_W{1'b0}}, w_al} * {{i420cr_pkg::DIM_W{1'b0}}, h_sat};
    luma_nxt = prod[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_r <= i420cr_pkg::RST_LUMA;
    end else begin
      luma_r <= luma_nxt;
    end
  end

  assign csize     = luma_r >> 2;
  assign uv_bound  = luma_r + csize;
  assign frame_end = luma_r + (luma_r >> 1);

  // pipeline handshake
  logic v1_r, v2_r, v3_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy   = !v3_r || out_ready;
  assign s2_rdy   = !v2_r || s3_rdy;
  assign s1_rdy   = !v1_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (s1_rdy) v1_r <= in_valid;
      if (s2_rdy) v2_r <= v1_r;
      if (s3_rdy) v3_r <= v2_r;
    end
  end

  // stage 1: capture transaction
  logic [OW-1:0]                 s1_off_r;
  logic [i420cr_pkg::BYTE_W-1:0] s1_byte_r;

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_off_r  <= in_data.src_offset;
      s1_byte_r <= in_data.src_byte;
    end
  end

  // stage 2: region compares
  logic [OW-1:0]                 s2_off_r;
  logic [i420cr_pkg::BYTE_W-1:0] s2_byte_r;
  logic                          s2_luma_r, s2_u_r, s2_in_r;
  logic                          lt_luma_nxt, lt_uv_nxt, lt_frame_nxt;

  always_comb begin
    lt_luma_nxt  = s1_off_r < luma_r;
    lt_uv_nxt    = s1_off_r < uv_bound;
    lt_frame_nxt = s1_off_r < frame_end;
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && v1_r) begin
      s2_off_r  <= s1_off_r;
      s2_byte_r <= s1_byte_r;
      s2_luma_r <= lt_luma_nxt;
      s2_u_r    <= lt_uv_nxt;
      s2_in_r   <= lt_frame_nxt;
    end
  end

  // stage 3: destination offset
  logic [OW:0]  add_a, add_b, sum;
  logic         add_sub;
  logic [OW:0]  off2;
  i420cr_pkg::out_item_t out_r, out_nxt;

  always_comb begin
    off2    = {s2_off_r, 1'b0};
    add_a   = {1'b0, s2_off_r};
    add_b   = '0;
    add_sub = 1'b0;
    if (!s2_luma_r) begin
      case (layout_r)
        i420cr_pkg::LAYOUT_YV12: begin
          add_b   = {1'b0, csize};
          add_sub = !s2_u_r;
        end
        i420cr_pkg::LAYOUT_NV12: begin
          add_sub = 1'b1;
          if (s2_u_r) begin
            add_a = off2;
            add_b = {1'b0, luma_r};
          end else begin
            add_a = off2 | {{OW{1'b0}}, 1'b1};
            add_b = {1'b0, frame_end};
          end
        end
        default: ;
      endcase
    end
    sum = add_sub ? (add_a - add_b) : (add_a + add_b);
    out_nxt.dest_offset = s2_in_r ? sum[OW-1:0] : '0;
    out_nxt.dest_byte   = s2_byte_r;
    out_nxt.in_frame    = s2_in_r;
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

// ===== bench/tb.sv =====
// testbench for the i420 chroma relayout mapper: directed corner items, then random traffic
`timescale 1ns / 100ps

module tb;

  localparam int unsigned OW = i420cr_pkg::OFFSET_W;
  localparam int unsigned BW = i420cr_pkg::BYTE_W;
  localparam int unsigned DW = i420cr_pkg::DIM_W;
  localparam int unsigned LW = i420cr_pkg::LAYOUT_W;

  localparam logic [i420cr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [i420cr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0]                    cfg_wdata;
  logic                             in_valid;
  logic                             in_ready;
  i420cr_pkg::in_item_t             in_data;
  logic                             out_valid;
  logic                             out_ready;
  i420cr_pkg::out_item_t            out_data;

  // local copy of the mapper configuration
  int unsigned          geo_width;
  int unsigned          geo_height;
  logic [LW-1:0]        geo_layout;
  int unsigned          luma_bytes;

  i420cr_pkg::out_item_t expected_pixels[$];
  int unsigned          mismatch_count;
  bit                   idle_on;
  bit                   stall_on;

  i420_chroma_relayout_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void refresh_luma();
    int unsigned w;
    int unsigned h;
    w = (geo_width > int'(i420cr_pkg::MAX_WIDTH)) ? int'(i420cr_pkg::MAX_WIDTH) : geo_width;
    h = (geo_height > int'(i420cr_pkg::MAX_HEIGHT)) ? int'(i420cr_pkg::MAX_HEIGHT)
                                                     : geo_height;
    w = (w + int'(i420cr_pkg::ROW_ALIGN_M1)) & ~int'(i420cr_pkg::ROW_ALIGN_M1);
    luma_bytes = w * h;
  endfunction

  function automatic i420cr_pkg::out_item_t remap_pixel(i420cr_pkg::in_item_t px);
    i420cr_pkg::out_item_t r;
    int unsigned csize;
    int unsigned frame;
    int unsigned off;
    int unsigned k;
    csize = luma_bytes / 4;
    frame = luma_bytes + 2 * csize;
    off = 32'(px.src_offset);
    r.dest_byte = px.src_byte;
    r.dest_offset = '0;
    r.in_frame = 1'b0;
    if (off < frame) begin
      r.in_frame = 1'b1;
      r.dest_offset = OW'(off);
      if (off >= luma_bytes && off < luma_bytes + csize) begin
        k = off - luma_bytes;
        if (geo_layout == i420cr_pkg::LAYOUT_YV12)
          r.dest_offset = OW'(luma_bytes + csize + k);
        else if (geo_layout == i420cr_pkg::LAYOUT_NV12)
          r.dest_offset = OW'(luma_bytes + 2 * k);
      end else if (off >= luma_bytes + csize) begin
        k = off - luma_bytes - csize;
        if (geo_layout == i420cr_pkg::LAYOUT_YV12)
          r.dest_offset = OW'(luma_bytes + k);
        else if (geo_layout == i420cr_pkg::LAYOUT_NV12)
          r.dest_offset = OW'(luma_bytes + 2 * k + 1);
      end
    end
    return r;
  endfunction

  // mostly plane interiors, some plane edges, some anywhere in the offset range
  function automatic int unsigned pick_offset();
    int unsigned csize;
    int unsigned edges[8];
    int unsigned r;
    csize = luma_bytes / 4;
    edges = '{0, luma_bytes - 1, luma_bytes, luma_bytes + csize - 1, luma_bytes + csize,
              luma_bytes + 2 * csize - 1, luma_bytes + 2 * csize, luma_bytes + 2 * csize + 1};
    r = $urandom_range(0, 99);
    if (luma_bytes == 0 || r < 8) return $urandom;
    if (r < 16) return edges[$urandom_range(0, 7)];
    if (r < 50) return $urandom_range(luma_bytes - 1, 0);
    if (r < 75) return luma_bytes + $urandom_range(csize - 1, 0);
    return luma_bytes + csize + $urandom_range(csize - 1, 0);
  endfunction

  task automatic send_pixel(input int unsigned offset, input int unsigned value);
    i420cr_pkg::in_item_t px;
    px.src_offset = OW'(offset);
    px.src_byte = BW'(value);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(remap_pixel(px));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [i420cr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      i420cr_pkg::REG_FRAME_WIDTH:   geo_width = 32'(val);
      i420cr_pkg::REG_FRAME_HEIGHT:  geo_height = 32'(val);
      i420cr_pkg::REG_OUTPUT_LAYOUT: geo_layout = val[LW-1:0];
      default: ;
    endcase
    refresh_luma();
  endtask

  task automatic reconfigure(input logic [DW-1:0] w, input logic [DW-1:0] h,
                             input logic [LW-1:0] layout);
    drain();
    write_reg(i420cr_pkg::REG_FRAME_WIDTH, w);
    write_reg(i420cr_pkg::REG_FRAME_HEIGHT, h);
    write_reg(i420cr_pkg::REG_OUTPUT_LAYOUT, {{(DW-LW){1'b0}}, layout});
  endtask

  // 1920 x 1080 i420 out of reset: plane edges and the top of the offset range
  task automatic test_reset_geometry();
    send_pixel(0, 'h00);
    send_pixel(luma_bytes - 1, 'hff);
    send_pixel(luma_bytes + luma_bytes / 2 - 1, 'h5a);
    send_pixel(luma_bytes + luma_bytes / 2, 'ha5);
    send_pixel('h1ff_ffff, 'hff);
  endtask

  // first and last byte of each chroma plane in every layout code
  task automatic test_layouts();
    int unsigned csize;
    for (int l = 0; l < 4; l++) begin
      reconfigure(13'd20, 13'd2, l[LW-1:0]);
      csize = luma_bytes / 4;
      send_pixel(luma_bytes, $urandom);
      send_pixel(luma_bytes + csize - 1, $urandom);
      send_pixel(luma_bytes + csize, $urandom);
      send_pixel(luma_bytes + 2 * csize - 1, $urandom);
    end
  endtask

  // zero width, saturated geometry, write to the unused register index
  task automatic test_degenerate_geometry();
    int unsigned frame;
    reconfigure(13'd0, 13'd8, i420cr_pkg::LAYOUT_NV12);
    send_pixel(0, 'h3c);
    reconfigure(13'd8191, 13'd8191, i420cr_pkg::LAYOUT_YV12);
    drain();
    write_reg(REG_UNUSED, 13'd17);
    frame = luma_bytes + luma_bytes / 2;
    send_pixel(frame - 1, 'hc3);
    send_pixel(frame, 'h81);
  endtask

  task automatic test_random_stream();
    int unsigned fixed_w[5] = '{1, 4096, 8191, 1, 33};
    int unsigned fixed_h[5] = '{1, 4096, 1, 8191, 0};
    logic [DW-1:0] w;
    logic [DW-1:0] h;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 5) begin
        w = DW'(fixed_w[ph]);
        h = DW'(fixed_h[ph]);
      end else begin
        w = DW'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 80) : $urandom_range(1, 8191));
        h = DW'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) : $urandom_range(1, 8191));
      end
      reconfigure(w, h, LW'(ph % 4));
      if (ph == 11) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end
      repeat (73) send_pixel(pick_offset(), $urandom);
    end
  endtask

  // random backpressure on the result side
  initial begin
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    i420cr_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: off %0d byte %0d in_frame %0b",
                   out_data.dest_offset, out_data.dest_byte, out_data.in_frame);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.dest_offset !== want.dest_offset || out_data.dest_byte !== want.dest_byte
            || out_data.in_frame !== want.in_frame) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b (off byte in_frame)",
                     want.dest_offset, want.dest_byte, want.in_frame,
                     out_data.dest_offset, out_data.dest_byte, out_data.in_frame);
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    mismatch_count = 0;
    geo_width = 32'(i420cr_pkg::RST_WIDTH);
    geo_height = 32'(i420cr_pkg::RST_HEIGHT);
    geo_layout = i420cr_pkg::LAYOUT_I420;
    refresh_luma();
    idle_on = 1'b1;
    stall_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_layouts();
    test_degenerate_geometry();
    test_random_stream();
    drain();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
